[sv/mdp_pkg.sv]
// Shared constants, opcodes and types for the matrix dot product engine.
// No dependencies; used by mdp_mac, mdp_core and matrix_dot_product_engine.
package mdp_pkg;

  localparam int DATA_W        = 32;
  localparam int IDX_W         = 4;
  localparam int OP_W          = 3;
  localparam int ORDER_W       = 5;
  localparam int MAX_ORDER_DEF = 16;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_LOAD_A   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B   = 3'd1;
  localparam logic [OP_W-1:0] OP_MULTIPLY = 3'd2;
  localparam logic [OP_W-1:0] OP_ROW_SUM  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  localparam logic KIND_MUL = 1'b0;
  localparam logic KIND_ROW = 1'b1;

  typedef struct packed {
    logic start;    // zero the accumulator for a new request
    logic step;     // memory read data is valid this cycle
    logic use_mul;  // multiply A by B, else pass C through
  } mac_ctl_t;

endpackage

[sv/mdp_mac.sv]
// Multiply-accumulate unit: registered product, then a wrapping 32-bit sum.
// Depends on mdp_pkg.
module mdp_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  mdp_pkg::mac_ctl_t          ctl,
  input  logic [mdp_pkg::DATA_W-1:0] a_data,
  input  logic [mdp_pkg::DATA_W-1:0] b_data,
  input  logic [mdp_pkg::DATA_W-1:0] c_data,
  output logic [mdp_pkg::DATA_W-1:0] acc,
  output logic                       busy
);

  logic                       prod_v;
  logic [mdp_pkg::DATA_W-1:0] prod;
  logic [mdp_pkg::DATA_W-1:0] mul_lo;

  // Low half of the product is all that wrapping arithmetic keeps.
  assign mul_lo = a_data * b_data;
  assign busy   = prod_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.step;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ctl.use_mul ? mul_lo : c_data;
    if (ctl.start) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + prod;
    end
  end

endmodule

[sv/mdp_core.sv]
// Sequencer, A/B/C matrix memories, running total and result register.
// Depends on mdp_pkg and mdp_mac.
module mdp_core #(
  parameter int MAX_ORDER = mdp_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mdp_pkg::ORDER_W-1:0] order,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mdp_pkg::OP_W-1:0]    opcode,
  input  logic [mdp_pkg::IDX_W-1:0]   row_index,
  input  logic [mdp_pkg::IDX_W-1:0]   col_index,
  input  logic signed [mdp_pkg::DATA_W-1:0] entry_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        done_kind,
  output logic [mdp_pkg::IDX_W-1:0]   done_row,
  output logic [mdp_pkg::IDX_W-1:0]   done_col,
  output logic signed [mdp_pkg::DATA_W-1:0] value,
  output logic signed [mdp_pkg::DATA_W-1:0] total
);

  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]                  state;
  logic [mdp_pkg::ORDER_W-1:0] cnt;
  logic [mdp_pkg::ORDER_W-1:0] n_r;
  logic [mdp_pkg::ORDER_W-1:0] n_cur;
  logic [mdp_pkg::IDX_W-1:0]   row_r;
  logic [mdp_pkg::IDX_W-1:0]   col_r;
  logic                        kind_r;
  logic                        rd_v;
  logic [mdp_pkg::DATA_W-1:0]  running_total;

  logic [mdp_pkg::DATA_W-1:0] a_mem [DEPTH];
  logic [mdp_pkg::DATA_W-1:0] b_mem [DEPTH];
  logic [mdp_pkg::DATA_W-1:0] c_mem [DEPTH];
  logic [mdp_pkg::DATA_W-1:0] a_q;
  logic [mdp_pkg::DATA_W-1:0] b_q;
  logic [mdp_pkg::DATA_W-1:0] c_q;

  logic          accept;
  logic          row_ok;
  logic          col_ok;
  logic          wr_a;
  logic          wr_b;
  logic          clr_total;
  logic          start;
  logic          start_kind;
  logic          fin;
  logic          rd_en;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] row_addr;
  logic [AW-1:0] col_addr;
  logic [AW-1:0] c_waddr;

  mdp_pkg::mac_ctl_t          mac_ctl;
  logic [mdp_pkg::DATA_W-1:0] acc;
  logic                       mac_busy;

  // Saturate the order in use to the memory size.
  assign n_cur = (32'(order) > MAX_ORDER) ? mdp_pkg::ORDER_W'(MAX_ORDER) : order;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign row_ok   = {1'b0, row_index} < n_cur;
  assign col_ok   = {1'b0, col_index} < n_cur;

  assign in_addr  = AW'(AW'(row_index) * AW'(MAX_ORDER) + AW'(col_index));
  assign row_addr = AW'(AW'(row_r) * AW'(MAX_ORDER) + AW'(cnt));
  assign col_addr = AW'(AW'(cnt) * AW'(MAX_ORDER) + AW'(col_r));
  assign c_waddr  = AW'(AW'(row_r) * AW'(MAX_ORDER) + AW'(col_r));

  assign rd_en = (state == ST_RUN);
  assign fin   = (state == ST_WAIT) && !rd_v && !mac_busy && (!out_valid || out_ready);

  always_comb begin
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    clr_total  = 1'b0;
    start      = 1'b0;
    start_kind = mdp_pkg::KIND_MUL;
    if (accept) begin
      case (opcode)
        mdp_pkg::OP_LOAD_A:   wr_a = row_ok && col_ok;
        mdp_pkg::OP_LOAD_B:   wr_b = row_ok && col_ok;
        mdp_pkg::OP_MULTIPLY: start = row_ok && col_ok;
        mdp_pkg::OP_ROW_SUM: begin
          start      = row_ok;
          start_kind = mdp_pkg::KIND_ROW;
        end
        mdp_pkg::OP_CLEAR:    clr_total = 1'b1;
        default:              start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_v  <= 1'b0;
    end else begin
      rd_v <= rd_en;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt == n_r - 1'b1) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (fin) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt    <= '0;
      n_r    <= n_cur;
      row_r  <= row_index;
      col_r  <= col_index;
      kind_r <= start_kind;
    end else if (rd_en) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[in_addr] <= entry_value;
    end
    if (rd_en) begin
      a_q <= a_mem[row_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_mem[in_addr] <= entry_value;
    end
    if (rd_en) begin
      b_q <= b_mem[col_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fin && (kind_r == mdp_pkg::KIND_MUL)) begin
      c_mem[c_waddr] <= acc;
    end
    if (rd_en) begin
      c_q <= c_mem[row_addr];
    end
  end

  assign mac_ctl.start   = start;
  assign mac_ctl.step    = rd_v;
  assign mac_ctl.use_mul = (kind_r == mdp_pkg::KIND_MUL);

  mdp_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .a_data (a_q),
    .b_data (b_q),
    .c_data (c_q),
    .acc    (acc),
    .busy   (mac_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (clr_total) begin
        running_total <= '0;
      end else if (fin && (kind_r == mdp_pkg::KIND_ROW)) begin
        running_total <= running_total + acc;
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      done_kind <= kind_r;
      done_row  <= row_r;
      done_col  <= (kind_r == mdp_pkg::KIND_ROW) ? '0 : col_r;
      value     <= acc;
      total     <= (kind_r == mdp_pkg::KIND_ROW) ? running_total + acc : running_total;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> cnt < n_r)
    else $error("read counter ran past the order in use");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !rd_v && !mac_busy)
    else $error("accumulator pipeline busy while idle");

  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    fin |=> out_valid && state == ST_IDLE)
    else $error("finished request did not post a result");

  a_kind_match: assert property (@(posedge clk) disable iff (rst)
    fin |=> done_kind == $past(kind_r))
    else $error("result kind differs from request kind");

endmodule

[sv/matrix_dot_product_engine.sv]
// Matrix dot product engine top level: order register and mdp_core; uses mdp_pkg.
// Load and clear requests act on acceptance; multiply and row-sum requests
// make one A/B/C memory read per term through the MAC, then post a result once
// the MAC has drained and the output register is free.
// A new request is taken while a finished result waits in the output register.
// Reset (rst, synchronous): order 16, running total zero, no result pending;
// matrix memories are not cleared and hold garbage until written.
module matrix_dot_product_engine #(
  parameter int MAX_ORDER = mdp_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: the order register
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mdp_pkg::ORDER_W-1:0] cfg_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mdp_pkg::OP_W-1:0]    opcode,
  input  logic [mdp_pkg::IDX_W-1:0]   row_index,
  input  logic [mdp_pkg::IDX_W-1:0]   col_index,
  input  logic signed [mdp_pkg::DATA_W-1:0] entry_value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        done_kind,
  output logic [mdp_pkg::IDX_W-1:0]   done_row,
  output logic [mdp_pkg::IDX_W-1:0]   done_col,
  output logic signed [mdp_pkg::DATA_W-1:0] value,
  output logic signed [mdp_pkg::DATA_W-1:0] total
);

  logic [mdp_pkg::ORDER_W-1:0] order;

  // Configuration writes go straight into the order register; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= mdp_pkg::ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      order <= cfg_data;
    end
  end

  // The core holds the three matrices, walks a row or column one term per
  // cycle, and keeps the result in an output register so the request side
  // can advance while the result side stalls.
  mdp_core #(
    .MAX_ORDER (MAX_ORDER)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .order       (order),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .row_index   (row_index),
    .col_index   (col_index),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .done_kind   (done_kind),
    .done_row    (done_row),
    .done_col    (done_col),
    .value       (value),
    .total       (total)
  );

endmodule

[tb/mdp_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the matrix dot product engine: tracks the order register,
// predicts every result from accepted requests and compares field by field.
// Depends on mdp_pkg for widths, opcodes and result kinds.
module mdp_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [mdp_pkg::ORDER_W-1:0]       cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [mdp_pkg::OP_W-1:0]          opcode,
  input  logic [mdp_pkg::IDX_W-1:0]         row_index,
  input  logic [mdp_pkg::IDX_W-1:0]         col_index,
  input  logic signed [mdp_pkg::DATA_W-1:0] entry_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              done_kind,
  input  logic [mdp_pkg::IDX_W-1:0]         done_row,
  input  logic [mdp_pkg::IDX_W-1:0]         done_col,
  input  logic signed [mdp_pkg::DATA_W-1:0] value,
  input  logic signed [mdp_pkg::DATA_W-1:0] total,
  output int                                errors,
  output int                                pending,
  output int                                results_seen
);

  localparam int SIDE  = mdp_pkg::MAX_ORDER_DEF;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = mdp_pkg::DATA_W;
  localparam int IW    = mdp_pkg::IDX_W;
  localparam int OW    = mdp_pkg::OP_W;

  typedef struct packed {
    logic          kind;
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    logic [DW-1:0] value;
    logic [DW-1:0] total;
  } matrix_result_t;

  logic [DW-1:0]                   mat_a [DEPTH];
  logic [DW-1:0]                   mat_b [DEPTH];
  logic [DW-1:0]                   mat_c [DEPTH];
  logic [DW-1:0]                   row_total;
  logic [mdp_pkg::ORDER_W-1:0]     order_reg;
  matrix_result_t                  awaited_results[$];
  int                              err_count = 0;
  int                              seen_count = 0;

  // Order in use saturates at the matrix side.
  function automatic int terms_in_use();
    return (order_reg > SIDE) ? SIDE : int'(order_reg);
  endfunction

  function automatic logic [AW-1:0] slot(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(int'(r) * SIDE + int'(c));
  endfunction

  task automatic check_field(input string name, input logic [DW-1:0] want,
                             input logic [DW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      err_count++;
    end
  endtask

  task automatic evaluate_request(input logic [OW-1:0] op, input logic [IW-1:0] r,
                                  input logic [IW-1:0] c, input logic [DW-1:0] v);
    int             n;
    int             i;
    logic [DW-1:0]  acc;
    matrix_result_t res;
    n = terms_in_use();
    acc = '0;
    if (op == mdp_pkg::OP_CLEAR) begin
      row_total = '0;
    end else if (op <= mdp_pkg::OP_ROW_SUM && r < n &&
                 (op == mdp_pkg::OP_ROW_SUM || c < n)) begin
      case (op)
        mdp_pkg::OP_LOAD_A: mat_a[slot(r, c)] = v;
        mdp_pkg::OP_LOAD_B: mat_b[slot(r, c)] = v;
        mdp_pkg::OP_MULTIPLY: begin
          for (i = 0; i < n; i++)
            acc = acc + mat_a[slot(r, IW'(i))] * mat_b[slot(IW'(i), c)];
          mat_c[slot(r, c)] = acc;
          res.kind = mdp_pkg::KIND_MUL;
          res.row = r;
          res.col = c;
          res.value = acc;
          res.total = row_total;
          awaited_results.push_back(res);
        end
        default: begin
          for (i = 0; i < n; i++) acc = acc + mat_c[slot(r, IW'(i))];
          row_total = row_total + acc;
          res.kind = mdp_pkg::KIND_ROW;
          res.row = r;
          res.col = '0;
          res.value = acc;
          res.total = row_total;
          awaited_results.push_back(res);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    matrix_result_t head;
    if (rst) begin
      order_reg = mdp_pkg::ORDER_RESET;
      row_total = '0;
      awaited_results.delete();
      for (int k = 0; k < DEPTH; k++) begin
        mat_a[AW'(k)] = '0;
        mat_b[AW'(k)] = '0;
        mat_c[AW'(k)] = '0;
      end
    end else begin
      // Compare first: a result can never belong to a request taken this edge.
      if (out_valid && out_ready) begin
        seen_count++;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: kind %0d row %0d col %0d value 0x%08h",
                 done_kind, done_row, done_col, value);
          err_count++;
        end else begin
          head = awaited_results.pop_front();
          check_field("done_kind", DW'(head.kind), DW'(done_kind));
          check_field("done_row", DW'(head.row), DW'(done_row));
          check_field("done_col", DW'(head.col), DW'(done_col));
          check_field("value", head.value, value);
          check_field("total", head.total, total);
        end
      end
      if (cfg_valid && cfg_ready) order_reg = cfg_data;
      if (in_valid && in_ready) evaluate_request(opcode, row_index, col_index, entry_value);
    end
    errors <= err_count;
    pending <= awaited_results.size();
    results_seen <= seen_count;
  end

endmodule

[tb/matrix_dot_product_engine_tb.sv]
`timescale 1ns / 100ps
// Top of the matrix dot product engine testbench: clock, reset, stimulus and verdict.
// Depends on mdp_pkg, the engine RTL and mdp_checker, which does all the checking.
module matrix_dot_product_engine_tb;

  localparam int SIDE       = mdp_pkg::MAX_ORDER_DEF;
  localparam int AW         = $clog2(SIDE * SIDE);
  localparam int DW         = mdp_pkg::DATA_W;
  localparam int IW         = mdp_pkg::IDX_W;
  localparam int OW         = mdp_pkg::OP_W;
  localparam int LIMIT      = 500000;
  localparam int SETTLE     = 48;   // settling margin past the slowest request
  localparam int NUM_PHASES = 10;
  localparam int PW         = $clog2(NUM_PHASES);
  localparam logic [OW-1:0] OP_TOP = {OW{1'b1}};
  // receiver stall modes
  localparam int RX_OPEN   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_CHOPPY = 2;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [mdp_pkg::ORDER_W-1:0]       cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [OW-1:0]                     opcode = '0;
  logic [IW-1:0]                     row_index = '0;
  logic [IW-1:0]                     col_index = '0;
  logic signed [DW-1:0]              entry_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              done_kind;
  logic [IW-1:0]                     done_row;
  logic [IW-1:0]                     done_col;
  logic signed [DW-1:0]              value;
  logic signed [DW-1:0]              total;

  int errors;
  int pending;
  int results_seen;

  // Stimulus-side bookkeeping: which matrix slots hold defined data.
  bit a_loaded [SIDE*SIDE];
  bit b_loaded [SIDE*SIDE];
  bit c_computed [SIDE*SIDE];
  int terms = SIDE;          // order in use, as the engine sees it
  int requests_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int rx_mode = RX_OPEN;
  int rx_mode_left = 0;
  int rx_hold_left = 0;
  int phase_order [NUM_PHASES] = '{16, 1, 0, 31, 5, 17, 9, 16, 3, 8};
  int phase_budget [NUM_PHASES] = '{200, 120, 60, 200, 200, 150, 200, 250, 150, 200};

  matrix_dot_product_engine uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .row_index  (row_index),
    .col_index  (col_index),
    .entry_value(entry_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .done_kind  (done_kind),
    .done_row   (done_row),
    .done_col   (done_col),
    .value      (value),
    .total      (total)
  );

  mdp_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .row_index   (row_index),
    .col_index   (col_index),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .done_kind   (done_kind),
    .done_row    (done_row),
    .done_col    (done_col),
    .value       (value),
    .total       (total),
    .errors      (errors),
    .pending     (pending),
    .results_seen(results_seen)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run as a failure once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result receiver: switch between always-ready, random and choppy stall modes
  // so that stalls land on every phase of a request's life.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(RX_OPEN, RX_CHOPPY);
        rx_mode_left <= $urandom_range(50, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          // hold low for long stretches, release briefly
          if (rx_hold_left == 0) begin
            out_ready <= ~out_ready;
            rx_hold_left <= out_ready ? $urandom_range(1, 30) : $urandom_range(1, 6);
          end else begin
            rx_hold_left <= rx_hold_left - 1;
          end
        end
      endcase
    end
  end

  function automatic logic [AW-1:0] slot(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(int'(r) * SIDE + int'(c));
  endfunction

  // Entry data: favor the signed extremes and small values, else anything.
  function automatic logic [DW-1:0] pick_entry();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32) - 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IW-1:0] pick_index();
    return IW'((terms == 0) ? $urandom_range(0, SIDE - 1) : $urandom_range(0, terms - 1));
  endfunction

  // Drop valid and sit out a random gap, then pick the next burst length.
  task automatic rest_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 10)) @(posedge clk);
    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
  endtask

  // Present one request and hold it until it is taken.
  task automatic send(input logic [OW-1:0] op, input logic [IW-1:0] r,
                      input logic [IW-1:0] c, input logic [DW-1:0] v);
    in_valid <= 1'b1;
    opcode <= op;
    row_index <= r;
    col_index <= c;
    entry_value <= v;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (r < terms && c < terms) begin
      if (op == mdp_pkg::OP_LOAD_A) a_loaded[slot(r, c)] = 1'b1;
      if (op == mdp_pkg::OP_LOAD_B) b_loaded[slot(r, c)] = 1'b1;
      if (op == mdp_pkg::OP_MULTIPLY) c_computed[slot(r, c)] = 1'b1;
    end
    if (burst_left > 0) burst_left--;
    else rest_sender();
  endtask

  // Load whatever of row r of A and column c of B is still undefined.
  task automatic load_operands(input logic [IW-1:0] r, input logic [IW-1:0] c);
    for (int i = 0; i < terms; i++) begin
      if (!a_loaded[slot(r, IW'(i))]) send(mdp_pkg::OP_LOAD_A, r, IW'(i), pick_entry());
      if (!b_loaded[slot(IW'(i), c)]) send(mdp_pkg::OP_LOAD_B, IW'(i), c, pick_entry());
    end
  endtask

  // Send a request, first filling in every entry it would read.
  task automatic issue(input logic [OW-1:0] op, input logic [IW-1:0] r,
                       input logic [IW-1:0] c, input logic [DW-1:0] v);
    if (op == mdp_pkg::OP_ROW_SUM && r < terms) begin
      for (int i = 0; i < terms; i++) begin
        if (!c_computed[slot(r, IW'(i))]) begin
          load_operands(r, IW'(i));
          send(mdp_pkg::OP_MULTIPLY, r, IW'(i), pick_entry());
        end
      end
    end
    if (op == mdp_pkg::OP_MULTIPLY && r < terms && c < terms) load_operands(r, c);
    send(op, r, c, v);
  endtask

  // Idle the request side until every expected result is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write the order register with the engine idle; settle past the slowest
  // request first.
  task automatic write_order(input int ord);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mdp_pkg::ORDER_W'(ord);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    terms = (ord > SIDE) ? SIDE : ord;
  endtask

  task automatic random_phase(input int budget);
    int            stop_at;
    int            pick;
    bit            paused;
    logic [OW-1:0] op;
    logic [IW-1:0] r;
    logic [IW-1:0] c;
    stop_at = requests_sent + budget;
    paused = 1'b0;
    while (requests_sent < stop_at) begin
      // pause once mid-phase until the engine has handed back everything
      if (!paused && requests_sent >= stop_at - budget / 2) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        issue(mdp_pkg::OP_MULTIPLY, pick_index(), pick_index(), pick_entry());
      end else if (pick < 50) begin
        issue(mdp_pkg::OP_ROW_SUM, pick_index(), IW'($urandom), pick_entry());
      end else if (pick < 72) begin
        op = $urandom_range(0, 1) ? mdp_pkg::OP_LOAD_A : mdp_pkg::OP_LOAD_B;
        issue(op, pick_index(), pick_index(), pick_entry());
      end else if (pick < 77) begin
        issue(mdp_pkg::OP_CLEAR, IW'($urandom), IW'($urandom), $urandom);
      end else if (pick < 85 && terms < SIDE) begin
        // index past the order in use: dropped by the engine
        op = OW'($urandom_range(mdp_pkg::OP_LOAD_A, mdp_pkg::OP_ROW_SUM));
        r = pick_index();
        c = pick_index();
        if (op == mdp_pkg::OP_ROW_SUM || $urandom_range(0, 1))
          r = IW'($urandom_range(terms, SIDE - 1));
        else c = IW'($urandom_range(terms, SIDE - 1));
        issue(op, r, c, pick_entry());
      end else if (pick < 92) begin
        issue(OW'($urandom_range(mdp_pkg::OP_CLEAR + 3'd1, OP_TOP)), IW'($urandom),
              IW'($urandom), $urandom);
      end else begin
        issue(OW'($urandom), IW'($urandom), IW'($urandom), pick_entry());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at order 2: signed extremes through both products and row
    // sums, clearing the total, unused opcodes and indexes past the order.
    write_order(2);
    issue(mdp_pkg::OP_LOAD_A, 4'd0, 4'd0, 32'h7fff_ffff);
    issue(mdp_pkg::OP_LOAD_A, 4'd0, 4'd1, 32'h8000_0000);
    issue(mdp_pkg::OP_LOAD_A, 4'd1, 4'd0, 32'hffff_ffff);
    issue(mdp_pkg::OP_LOAD_A, 4'd1, 4'd1, 32'h0000_0000);
    issue(mdp_pkg::OP_LOAD_B, 4'd0, 4'd0, 32'h7fff_ffff);
    issue(mdp_pkg::OP_LOAD_B, 4'd0, 4'd1, 32'h0000_0001);
    issue(mdp_pkg::OP_LOAD_B, 4'd1, 4'd0, 32'h8000_0000);
    issue(mdp_pkg::OP_LOAD_B, 4'd1, 4'd1, 32'hffff_ffff);
    issue(mdp_pkg::OP_MULTIPLY, 4'd0, 4'd0, '0);
    issue(mdp_pkg::OP_MULTIPLY, 4'd0, 4'd1, '0);
    issue(mdp_pkg::OP_MULTIPLY, 4'd1, 4'd0, '0);
    issue(mdp_pkg::OP_MULTIPLY, 4'd1, 4'd1, '1);
    issue(mdp_pkg::OP_ROW_SUM, 4'd0, 4'd0, '0);
    issue(mdp_pkg::OP_ROW_SUM, 4'd1, 4'd15, '0);
    issue(mdp_pkg::OP_CLEAR, 4'd15, 4'd15, '1);
    issue(mdp_pkg::OP_ROW_SUM, 4'd1, 4'd0, '0);
    issue(mdp_pkg::OP_CLEAR + 3'd1, 4'd15, 4'd15, '1);
    issue(mdp_pkg::OP_CLEAR + 3'd2, 4'd0, 4'd0, '0);
    issue(OP_TOP, 4'd15, 4'd15, '1);
    issue(mdp_pkg::OP_LOAD_A, 4'd15, 4'd0, 32'h1234_5678);
    issue(mdp_pkg::OP_LOAD_B, 4'd0, 4'd15, 32'h1234_5678);
    issue(mdp_pkg::OP_MULTIPLY, 4'd1, 4'd2, '0);
    issue(mdp_pkg::OP_ROW_SUM, 4'd2, 4'd0, '0);

    // Random part: walk the order through its extremes and a few in between.
    phase_order[6] = $urandom_range(2, SIDE - 1);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_order(phase_order[PW'(p)]);
      random_phase(phase_budget[PW'(p)]);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("coverage: %0d requests over %0d order settings (0, 1, 16, 31 among them)",
             requests_sent, NUM_PHASES + 1);
    $display("coverage: %0d results checked, %0d mismatches, %0d still outstanding",
             results_seen, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
